@@ design/stsw_pkg.sv @@
// Package for the target-sum sliding window block.
// Holds the controller state type, status codes and fixed field widths.
// Depends on nothing; used by the top level and its checker.
package stsw_pkg;

    localparam int VAL_W = 32;
    localparam int SUM_W = 48;
    localparam int POS_W = 16;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_FOUND     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

    // Register index of target_sum, taken from paddr[3].
    localparam logic REG_TARGET_SUM = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

endpackage

@@ design/stsw_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module stsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/subarray_target_sum_window.sv @@
// Top level of the target-sum sliding window search.
// Depends on stsw_pkg and stsw_ram.
//
// Channel   Dir  Handshake          Beat contents
// s_*       in   tvalid/tready      tdata: value[31:0]; tlast: last
// m_*       out  tvalid/tready      tdata: start[15:0], end[31:16]; tuser: status
// APB       in   psel/penable       target_sum at byte address 0, 64-bit data
//
// An element is accepted in ST_IDLE and decided in ST_POP, which first drops
// elements from the window one by one, since every drop reads the oldest entry
// from the window RAM through its single registered read port.
// A beat after a found run or an overflow is accepted in ST_IDLE with no decision.
// Reset is synchronous and clears the window state; RAM contents are not cleared.
// A stalled result holds the decision cycle of the next element that reports,
// and the input waits with it; elements that report nothing pass.
module subarray_target_sum_window
    import stsw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 1024,
    parameter longint unsigned MAX_LEN = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VAL_W-1:0]   s_tdata,   // value
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [2*POS_W-1:0] m_tdata,   // start_index, end_index
    output logic [STAT_W-1:0]  m_tuser,   // status
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam longint unsigned PosLimitL = (MAX_LEN < 65535) ? MAX_LEN : 65535;
    localparam logic [POS_W-1:0] POS_LIMIT = PosLimitL[POS_W-1:0];

    t_state r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [POS_W-1:0]  r_start_pos, n_start_pos;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_done, n_done;
    logic              r_last, n_last;
    logic              r_ovf, n_ovf;
    logic [SUM_W-1:0]  r_target;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [POS_W-1:0]  r_out_start, n_out_start;
    logic [POS_W-1:0]  r_out_end, n_out_end;

    logic             accept, out_free, full, pop, hit, emit, finish, we;
    logic [AW-1:0]    head_inc, slot;
    logic [CW:0]      slot_sum;
    logic [VAL_W-1:0] rdata;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;
    assign full     = (r_count >= CW'(WINDOW_DEPTH)) || (r_pos >= POS_LIMIT);
    assign pop      = (r_state == ST_POP) && !r_ovf && (r_sum > r_target)
                      && (r_count > CW'(1));
    assign hit      = (r_sum == r_target);
    assign emit     = r_ovf || hit || r_last;
    assign finish   = (r_state == ST_POP) && !pop && (!emit || out_free);
    assign head_inc = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign slot_sum = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign slot     = (slot_sum >= (CW + 1)'(WINDOW_DEPTH))
                      ? AW'(slot_sum - (CW + 1)'(WINDOW_DEPTH)) : AW'(slot_sum);
    assign we       = accept && !r_done && !full;

    stsw_ram #(
        .WIDTH(VAL_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(slot),
        .i_wdata(s_tdata),
        .i_raddr(n_head),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !r_done) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_sum        = r_sum;
        n_start_pos  = r_start_pos;
        n_pos        = r_pos;
        n_done       = r_done;
        n_last       = r_last;
        n_ovf        = r_ovf;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        if (accept) begin
            if (r_done) begin
                if (s_tlast) begin
                    n_head      = '0;
                    n_count     = '0;
                    n_sum       = '0;
                    n_start_pos = POS_W'(1);
                    n_pos       = '0;
                    n_done      = 1'b0;
                end
            end else begin
                n_last = s_tlast;
                n_ovf  = full;
                if (!full) begin
                    n_pos   = r_pos + 1'b1;
                    n_count = r_count + 1'b1;
                    n_sum   = r_sum + SUM_W'(s_tdata);
                end
            end
        end else if (pop) begin
            n_sum       = r_sum - SUM_W'(rdata);
            n_head      = head_inc;
            n_count     = r_count - 1'b1;
            n_start_pos = r_start_pos + 1'b1;
        end else if (finish) begin
            if (emit) begin
                n_out_valid = 1'b1;
                if (r_ovf) begin
                    n_out_status = STAT_OVERFLOW;
                    n_out_start  = '0;
                    n_out_end    = '0;
                end else if (hit) begin
                    n_out_status = STAT_FOUND;
                    n_out_start  = r_start_pos;
                    n_out_end    = r_pos;
                end else begin
                    n_out_status = STAT_NOT_FOUND;
                    n_out_start  = '0;
                    n_out_end    = '0;
                end
                n_done = r_ovf || hit;
            end
            if (r_last) begin
                n_head      = '0;
                n_count     = '0;
                n_sum       = '0;
                n_start_pos = POS_W'(1);
                n_pos       = '0;
                n_done      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_start_pos <= POS_W'(1);
            r_pos       <= '0;
            r_done      <= 1'b0;
            r_last      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_target    <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_start_pos <= n_start_pos;
            r_pos       <= n_pos;
            r_done      <= n_done;
            r_last      <= n_last;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && (paddr[3] == REG_TARGET_SUM)) begin
                r_target <= pwdata[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
    end

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_end, r_out_start};
    assign m_tuser  = r_out_status;
    assign prdata   = (paddr[3] == REG_TARGET_SUM) ? {{(64 - SUM_W){1'b0}}, r_target} : '0;
    assign pready   = 1'b1;

endmodule

@@ design/stsw_checker.sv @@
// Port-level checker for the target-sum sliding window block.
// Depends on stsw_pkg; bound to subarray_target_sum_window below.
module stsw_checker
    import stsw_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [2*POS_W-1:0] m_tdata,
    input logic [STAT_W-1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result beat changed while stalled.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == STAT_FOUND) || (m_tuser == STAT_NOT_FOUND)
                     || (m_tuser == STAT_OVERFLOW))
        else $error("Unknown status code.");

    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != STAT_FOUND) |-> (m_tdata == '0))
        else $error("Positions must be zero unless a run was found.");

    a_found_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == STAT_FOUND) |->
            (m_tdata[POS_W-1:0] != '0) && (m_tdata[POS_W-1:0] <= m_tdata[2*POS_W-1:POS_W]))
        else $error("Found run has an empty or reversed range.");

endmodule

bind subarray_target_sum_window stsw_checker u_stsw_checker (.*);

@@ test/subarray_target_sum_window_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for subarray_target_sum_window: streams arrays into the
// search, predicts every report in a clocked model and checks each result beat.
// Depends on stsw_pkg and the subarray_target_sum_window RTL.
module subarray_target_sum_window_tb;
    import stsw_pkg::*;

    localparam int WIN_DEPTH = 1024;
    localparam int WIN_AW = $clog2(WIN_DEPTH);
    localparam logic [POS_W-1:0] POS_LIMIT = 16'hFFFF;
    localparam int SETTLE_CYCLES = 1100;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [SUM_W-1:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] VAL_MAX = 48'h0000_FFFF_FFFF;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_element;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
    } t_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VAL_W-1:0]   s_tdata = '0;   // value
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [2*POS_W-1:0] m_tdata;        // start_index, end_index
    logic [STAT_W-1:0]  m_tuser;        // status
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;

    subarray_target_sum_window u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_element element_q[$];
    t_report  report_q[$];

    // Copy of the window search state.
    logic [VAL_W-1:0] win_mem [WIN_DEPTH];
    int unsigned      win_head;
    int unsigned      win_cnt;
    logic [SUM_W-1:0] win_sum;
    logic [POS_W-1:0] run_start;
    logic [POS_W-1:0] elem_pos;
    bit               search_done;
    logic [SUM_W-1:0] goal_sum;

    int  errors = 0;
    int  items_sent = 0;
    int  found_cnt = 0;
    int  miss_cnt = 0;
    int  ovf_cnt = 0;
    int  cycle_cnt = 0;
    int  hold_req = 0;
    bit  no_idle = 1'b0;

    function automatic void clear_window();
        win_head = 0;
        win_cnt = 0;
        win_sum = '0;
        run_start = 16'd1;
        elem_pos = '0;
        search_done = 1'b0;
    endfunction

    function automatic void add_report(logic [STAT_W-1:0] st, logic [POS_W-1:0] first,
                                       logic [POS_W-1:0] final_pos);
        t_report r;
        r.status = st;
        r.start_pos = first;
        r.end_pos = final_pos;
        report_q.push_back(r);
    endfunction

    function automatic void search_step(logic [VAL_W-1:0] val, logic fin);
        int unsigned slot;
        if (!search_done) begin
            if (elem_pos >= POS_LIMIT || win_cnt >= WIN_DEPTH) begin
                add_report(STAT_OVERFLOW, '0, '0);
                search_done = 1'b1;
            end else begin
                elem_pos = elem_pos + 1'b1;
                slot = (win_head + win_cnt) % WIN_DEPTH;
                win_mem[slot[WIN_AW-1:0]] = val;
                win_cnt++;
                win_sum = win_sum + val;
                while (win_sum > goal_sum && win_cnt > 1) begin
                    win_sum = win_sum - win_mem[win_head[WIN_AW-1:0]];
                    win_head = (win_head + 1) % WIN_DEPTH;
                    win_cnt--;
                    run_start = run_start + 1'b1;
                end
                if (win_sum == goal_sum) begin
                    add_report(STAT_FOUND, run_start, elem_pos);
                    search_done = 1'b1;
                end else if (fin) begin
                    add_report(STAT_NOT_FOUND, '0, '0);
                end
            end
        end
        if (fin)
            clear_window();
    endfunction

    // Driver: offers the oldest pending element and updates the prediction on each beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                search_step(element_q[0].value, element_q[0].last);
                element_q.delete(0);
                items_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (element_q.size() > 0 && (no_idle || $urandom_range(99) >= 32)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= element_q[0].value;
                    s_tlast <= element_q[0].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest predicted report.
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.start_pos = m_tdata[POS_W-1:0];
                got.end_pos = m_tdata[2*POS_W-1:POS_W];
                case (got.status)
                    STAT_FOUND:     found_cnt++;
                    STAT_NOT_FOUND: miss_cnt++;
                    default:        ovf_cnt++;
                endcase
                if (report_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected report, got status %0d start %0d end %0d",
                             $time, got.status, got.start_pos, got.end_pos);
                end else begin
                    want = report_q.pop_front();
                    if (got != want) begin
                        errors++;
                        $display({"%0t: report mismatch, expected status %0d start %0d end %0d,",
                                  " got status %0d start %0d end %0d"}, $time,
                                 want.status, want.start_pos, want.end_pos,
                                 got.status, got.start_pos, got.end_pos);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 32);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d reports outstanding",
                     cycle_cnt, report_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_element(logic [VAL_W-1:0] v, logic fin);
        t_element e;
        e.value = v;
        e.last = fin;
        element_q.push_back(e);
    endtask

    task automatic wait_idle();
        while (element_q.size() != 0 || report_q.size() != 0 || s_tvalid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_target(logic [SUM_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TARGET_SUM, 3'b000};
        pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        goal_sum = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[SUM_W-1:0] !== v) begin
            errors++;
            $display("%0t: target readback mismatch, expected %0h, got %0h",
                     $time, v, prdata[SUM_W-1:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_array(logic [SUM_W-1:0] goal, ref int added);
        logic [VAL_W-1:0] vals[$];
        logic [VAL_W-1:0] cap;
        logic [VAL_W-1:0] v;
        logic [SUM_W-1:0] rest;
        int unsigned len;
        int unsigned plant_at;
        int unsigned pick;
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
        cap = (goal > VAL_MAX) ? 32'hFFFF_FFFF : goal[VAL_W-1:0];
        plant_at = ($urandom_range(1) == 1) ? $urandom_range(len - 1, 0) : len;
        for (int i = 0; i < len; i++) begin
            if (i == plant_at && goal < 48'h2_0000_0000) begin
                // Plant a short run that sums exactly to the target.
                rest = goal;
                if (rest <= VAL_MAX && $urandom_range(1) == 1) begin
                    v = $urandom_range(rest[VAL_W-1:0], 0);
                    vals.push_back(v);
                    rest = rest - v;
                end
                while (rest > VAL_MAX) begin
                    vals.push_back(32'hFFFF_FFFF);
                    rest = rest - VAL_MAX;
                end
                vals.push_back(rest[VAL_W-1:0]);
            end
            pick = $urandom_range(9);
            if (pick < 2)
                v = $urandom();
            else if (pick == 2)
                v = '0;
            else if (cap == 0)
                v = $urandom_range(3);
            else
                v = $urandom_range(cap / $urandom_range(4, 1), 0);
            vals.push_back(v);
        end
        foreach (vals[k])
            send_element(vals[k], k == vals.size() - 1);
        added += vals.size();
    endtask

    initial begin
        logic [SUM_W-1:0] goal;
        int added;
        clear_window();
        goal_sum = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Target still at its reset value of zero.
        send_element(32'd5, 1'b0);
        send_element(32'd0, 1'b0);
        send_element(32'd7, 1'b1);
        send_element(32'd0, 1'b1);
        send_element(32'hFFFF_FFFF, 1'b1);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'd1, 1'b1);
        wait_idle();

        set_target(48'd10);
        send_element(32'd3, 1'b0);
        send_element(32'd4, 1'b0);
        send_element(32'd3, 1'b1);
        send_element(32'd11, 1'b0);
        send_element(32'd10, 1'b1);
        send_element(32'd1, 1'b0);
        send_element(32'd2, 1'b1);
        wait_idle();

        set_target(SUM_MAX);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'd0, 1'b1);
        wait_idle();

        // One array that fills the window store and overruns it, sent without gaps.
        no_idle = 1'b1;
        for (int i = 0; i < WIN_DEPTH + 6; i++)
            send_element($urandom(), i == WIN_DEPTH + 5);
        wait_idle();
        no_idle = 1'b0;

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: goal = 48'd0;
                1: goal = 48'd1;
                2: goal = 48'd7;
                3: goal = SUM_W'($urandom_range(255, 2));
                4: goal = SUM_W'($urandom_range(16'hFFFF, 256));
                5: goal = {16'd0, $urandom()};
                6: goal = 48'h1_0000_0000 + SUM_W'($urandom_range(16'hFFFF));
                7: goal = {$urandom(), $urandom()} >> 16;
                default: goal = SUM_MAX;
            endcase
            set_target(goal);
            added = 0;
            while (added < 50)
                send_array(goal, added);
            if (ph == 3)
                hold_req++;
            wait_idle();
        end

        if (report_q.size() != 0) begin
            errors++;
            $display("%0t: %0d reports never arrived", $time, report_q.size());
        end
        $display("Sent %0d elements over directed, window capacity and random target phases.",
                 items_sent);
        $display("Checked %0d found, %0d not-found and %0d overflow reports; %0d errors.",
                 found_cnt, miss_cnt, ovf_cnt, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
